@@ design/lbtc_pkg.sv @@
// Shared constants, operation codes and controller interface types of the LRU block tag cache.
`timescale 1ns / 1ps

package lbtc_pkg;

   // Table geometry and key widths.
   localparam int ENTRIES       = 64;
   localparam int DISK_ID_BITS  = 8;
   localparam int BLOCK_ID_BITS = 16;
   localparam int TIME_BITS     = 32;
   localparam int CAP_BITS      = 7;
   localparam int SLOT_BITS     = $clog2(ENTRIES);
   localparam int CNT_BITS      = $clog2(ENTRIES + 1);
   localparam int CMD_BITS      = 2;

   // One stored entry: key in the low bits, time of last use above it.
   localparam int KEY_BITS      = DISK_ID_BITS + BLOCK_ID_BITS;
   localparam int WORD_BITS     = KEY_BITS + TIME_BITS;

   // Request and response packing on the stream buses, padded to whole bytes.
   localparam int REQ_BITS      = CMD_BITS + DISK_ID_BITS + BLOCK_ID_BITS;
   localparam int REQ_DATA_BITS = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS      = 3 + SLOT_BITS;
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   // Operation codes.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_GET   = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } lbtc_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_step;
      logic commit;
   } lbtc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_skip;
      logic scan_last;
      logic out_free;
   } lbtc_stat_type;

endpackage

@@ design/lbtc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lbtc_ram #(
   parameter int  WIDTH     = 8,
   parameter int  DEPTH     = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/lbtc_ctrl.sv @@
// Sequencing state machine of the LRU block tag cache.
`timescale 1ns / 1ps

module lbtc_ctrl
   import lbtc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  lbtc_stat_type stat,
   output lbtc_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state: walk the filled slots, let the last read land, then commit.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (stat.scan_skip) begin
               state_in = ST_COMMIT;
            end else if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath.
   assign req_tready    = (state_ff == ST_IDLE);
   assign cmd.load      = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.scan_step = (state_ff == ST_SCAN) && !stat.scan_skip;
   assign cmd.commit    = (state_ff == ST_COMMIT) && stat.out_free;

endmodule

@@ design/lbtc_datapath.sv @@
// Tag store, scan compare, LRU search, counters and response register of the tag cache.
`timescale 1ns / 1ps

module lbtc_datapath
   import lbtc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  lbtc_cmd_type             cmd,
   output lbtc_stat_type            stat,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     csr_wr_en,
   input  logic [CAP_BITS-1:0]      csr_wr_data,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // Latched transaction.
   lbtc_op_type              op_ff;
   logic [DISK_ID_BITS-1:0]  disk_ff;
   logic [BLOCK_ID_BITS-1:0] block_ff;

   // Persistent state.
   logic [TIME_BITS-1:0]     time_ff;
   logic [CNT_BITS-1:0]      fill_ff;
   logic [CAP_BITS-1:0]      cap_ff;

   // Scan state.
   logic [SLOT_BITS-1:0]     idx_ff;
   logic                     cmp_vld_ff;
   logic [SLOT_BITS-1:0]     cmp_idx_ff;
   logic                     hit_ff;
   logic [SLOT_BITS-1:0]     hit_slot_ff;
   logic [SLOT_BITS-1:0]     best_slot_ff;
   logic [TIME_BITS-1:0]     best_age_ff;

   // Response register.
   logic                     rsp_tvalid_ff;
   logic                     rsp_hit_ff;
   logic                     rsp_valid_ff;
   logic [SLOT_BITS-1:0]     rsp_slot_ff;
   logic                     rsp_evicted_ff;

   logic                     is_getput;
   logic [CNT_BITS-1:0]      cap_eff;
   logic                     has_room;
   logic [WORD_BITS-1:0]     rd_word;
   logic [TIME_BITS-1:0]     rd_age;
   logic                     rd_match;
   logic                     wr_en;
   logic [SLOT_BITS-1:0]     wr_slot;

   assign is_getput = (op_ff == CMD_GET) || (op_ff == CMD_PUT);

   // Capacity register clamped into one to the entry count.
   always_comb begin
      priority if (cap_ff == '0) begin
         cap_eff = CNT_BITS'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = CNT_BITS'(ENTRIES);
      end else begin
         cap_eff = CNT_BITS'(cap_ff);
      end
   end

   assign has_room = (fill_ff < cap_eff);

   // Status for the controller.
   assign stat.scan_skip = !is_getput || (fill_ff == '0);
   assign stat.scan_last = ((CNT_BITS'(idx_ff) + CNT_BITS'(1)) == fill_ff);
   assign stat.out_free  = !rsp_tvalid_ff || rsp_tready;

   // Compare of the entry read in the previous cycle.
   assign rd_match = (rd_word[KEY_BITS-1:0] == {block_ff, disk_ff});
   assign rd_age   = time_ff - rd_word[WORD_BITS-1:KEY_BITS];

   // Slot written at commit: a hit refreshes, a put miss fills or replaces.
   always_comb begin
      priority if (hit_ff) begin
         wr_slot = hit_slot_ff;
      end else if (has_room) begin
         wr_slot = fill_ff[SLOT_BITS-1:0];
      end else begin
         wr_slot = best_slot_ff;
      end
   end

   assign wr_en = cmd.commit && is_getput && (hit_ff || (op_ff == CMD_PUT));

   lbtc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data ({time_ff, block_ff, disk_ff}),
      .rd_en   (cmd.scan_step),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   // Transaction latch and scan bookkeeping.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= lbtc_op_type'(req_tdata[CMD_BITS-1:0]);
         disk_ff  <= req_tdata[CMD_BITS +: DISK_ID_BITS];
         block_ff <= req_tdata[CMD_BITS+DISK_ID_BITS +: BLOCK_ID_BITS];
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            idx_ff     <= idx_ff + SLOT_BITS'(1);
         end
         if (cmp_vld_ff) begin
            if (!hit_ff && rd_match) begin
               hit_ff      <= 1'b1;
               hit_slot_ff <= cmp_idx_ff;
            end
            if ((cmp_idx_ff == '0) || (rd_age > best_age_ff)) begin
               best_slot_ff <= cmp_idx_ff;
               best_age_ff  <= rd_age;
            end
         end
      end
      cmp_idx_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_step;
      end
   end

   // Capacity register, fill count and time counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_BITS'(ENTRIES);
         fill_ff <= '0;
         time_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            unique case (op_ff)
               CMD_GET: begin
                  time_ff <= time_ff + TIME_BITS'(1);
               end
               CMD_PUT: begin
                  time_ff <= time_ff + TIME_BITS'(1);
                  if (!hit_ff && has_room) begin
                     fill_ff <= fill_ff + CNT_BITS'(1);
                  end
               end
               CMD_CLEAR: begin
                  fill_ff <= '0;
                  time_ff <= '0;
               end
               CMD_NOP: begin
                  fill_ff <= fill_ff;
               end
            endcase
         end
      end
   end

   // Response register: loaded at commit, held until the transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff     <= is_getput && hit_ff;
         rsp_valid_ff   <= is_getput && (hit_ff || (op_ff == CMD_PUT));
         rsp_evicted_ff <= (op_ff == CMD_PUT) && !hit_ff && !has_room;
         if (is_getput && (hit_ff || (op_ff == CMD_PUT))) begin
            rsp_slot_ff <= wr_slot;
         end else begin
            rsp_slot_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_evicted_ff, rsp_slot_ff, rsp_valid_ff, rsp_hit_ff});

endmodule

@@ design/lru_block_tag_cache_unit.sv @@
// Top level of the LRU block tag cache: controller, datapath and stream ports.
`timescale 1ns / 1ps

// Fully associative tag cache for (disk, block) keys with least-recently-used
// replacement. Get looks a key up and refreshes it on a hit; put refreshes on
// a hit, otherwise fills the next free slot below the capacity register or
// replaces the entry with the oldest time stamp (lowest slot on a tie); clear
// empties the table and zeroes the time counter. The returned slot indexes an
// external data memory. Each get or put reads the filled slots one per cycle
// from the tag RAM, waits for the last read to land and then commits; a clear,
// a no-operation or a get or put on an empty table skips the scan. Exactly one
// response follows every request, and the next request is taken once the
// previous response is registered. The capacity register may be written only
// while no transaction is in flight.

module lru_block_tag_cache_unit
   import lbtc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request stream.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [1:0] command, [9:2] disk_id, [25:10] block_id, upper bits zero
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // Response stream.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] hit, [1] slot_valid, [7:2] slot, [8] evicted, upper bits zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // Capacity register write.
   input  logic                     csr_wr_en,
   input  logic [CAP_BITS-1:0]      csr_wr_data
);

   lbtc_cmd_type  cmd;
   lbtc_stat_type stat;

   lbtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lbtc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
